// ===== rtl/core/swsid_pkg.sv =====
package swsid_pkg;

    localparam int DataWidth    = 32;
    localparam int DefaultDepth = 16;
    localparam int FuncWidth    = 3;
    localparam int StatusWidth  = 2;
    localparam int CountWidth   = 5;
    localparam int InTdataWidth = 72;
    localparam int OutTdataWidth = 40;

    localparam logic [FuncWidth-1:0] FN_PUSH   = 3'd0;
    localparam logic [FuncWidth-1:0] FN_POP    = 3'd1;
    localparam logic [FuncWidth-1:0] FN_INSERT = 3'd2;
    localparam logic [FuncWidth-1:0] FN_DELETE = 3'd3;
    localparam logic [FuncWidth-1:0] FN_CLEAR  = 3'd4;

    localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
    localparam logic [StatusWidth-1:0] ST_EMPTY     = 2'd1;
    localparam logic [StatusWidth-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [StatusWidth-1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP,
        OP_START,
        OP_STEP,
        OP_INS,
        OP_DEL
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_APPLY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [DataWidth-1:0] data;
        logic                 tok;
    } t_link;

endpackage

// ===== rtl/core/stack_with_search_insert_delete.sv =====
// Channel  Direction  tdata fields (lowest bit up)                    tuser  tlast
// s        in         func[2:0] value[34:3] key[66:35], pad to 72     -      -
// m        out        popped_value[31:0] status[33:32]                -      -
//                     entry_count[38:34], pad to 40
// One request is in work at a time; a new one is taken while a result waits on m.
// Push, pop, clear, unknown codes and requests refused at once go from dispatch straight
// to the done state. A search ends on a match or after the last entry, as a token walks
// the chain of cells one cell a cycle from the top.
// The synchronous reset empties the list; the entries themselves are not cleared.
// A stalled m side holds the finished result and the engine waits after one request.
module stack_with_search_insert_delete #(
    parameter int DEPTH = swsid_pkg::DefaultDepth
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [swsid_pkg::InTdataWidth-1:0]   i_s_tdata,  // func, value, key
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [swsid_pkg::OutTdataWidth-1:0]  o_m_tdata   // popped_value, status, entry_count
);

    localparam int DW = swsid_pkg::DataWidth;
    localparam int FW = swsid_pkg::FuncWidth;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = $clog2(DEPTH);

    swsid_pkg::t_state   r_state, n_state;
    swsid_pkg::t_cell_op w_op;
    logic [FW-1:0]       r_func, n_func;
    logic [DW-1:0]       r_val, n_val;
    logic [DW-1:0]       r_key, n_key;
    logic [CW-1:0]       r_count, n_count;
    logic [KW-1:0]       r_k, n_k;
    logic [DW-1:0]       r_pop, n_pop;
    logic [swsid_pkg::StatusWidth-1:0] r_stat, n_stat;
    logic                r_ovalid, n_ovalid;
    logic [DW-1:0]       r_o_pop, n_o_pop;
    logic [swsid_pkg::StatusWidth-1:0] r_o_stat, n_o_stat;
    logic [swsid_pkg::CountWidth-1:0]  r_o_count, n_o_count;

    logic [DW-1:0]       w_search;
    swsid_pkg::t_link    w_link [DEPTH];
    logic [DEPTH-1:0]    w_hit;
    logic                w_full;
    logic                w_empty;

    assign w_full   = r_count == CW'(DEPTH);
    assign w_empty  = r_count == '0;
    assign w_search = (r_func == swsid_pkg::FN_INSERT) ? r_key : r_val;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        swsid_pkg::t_link w_prev;
        logic [DW-1:0]    w_next;
        if (g == 0) begin : g_first
            assign w_prev.data = r_val;
            assign w_prev.tok  = 1'b0;
        end else begin : g_mid
            assign w_prev = w_link[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_link[g+1].data;
        end
        swsid_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (w_op),
            .i_val       (r_val),
            .i_key       (w_search),
            .i_count     (r_count),
            .i_prev      (w_prev),
            .i_next_data (w_next),
            .o_link      (w_link[g]),
            .o_hit       (w_hit[g])
        );
    end

    assign o_s_tready = (r_state == swsid_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_o_count, r_o_stat, r_o_pop};

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_val     = r_val;
        n_key     = r_key;
        n_count   = r_count;
        n_k       = r_k;
        n_pop     = r_pop;
        n_stat    = r_stat;
        n_ovalid  = r_ovalid;
        n_o_pop   = r_o_pop;
        n_o_stat  = r_o_stat;
        n_o_count = r_o_count;
        w_op      = swsid_pkg::OP_HOLD;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            swsid_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_func  = i_s_tdata[FW-1:0];
                    n_val   = i_s_tdata[FW+DW-1:FW];
                    n_key   = i_s_tdata[FW+2*DW-1:FW+DW];
                    n_state = swsid_pkg::S_DISPATCH;
                end
            end
            swsid_pkg::S_DISPATCH: begin
                n_pop   = '0;
                n_stat  = swsid_pkg::ST_OK;
                n_k     = '0;
                n_state = swsid_pkg::S_DONE;
                unique case (r_func)
                    swsid_pkg::FN_PUSH: begin
                        if (w_full) begin
                            n_stat = swsid_pkg::ST_FULL;
                        end else begin
                            w_op    = swsid_pkg::OP_PUSH;
                            n_count = r_count + 1'b1;
                        end
                    end
                    swsid_pkg::FN_POP: begin
                        if (w_empty) begin
                            n_stat = swsid_pkg::ST_EMPTY;
                        end else begin
                            w_op    = swsid_pkg::OP_POP;
                            n_pop   = w_link[0].data;
                            n_count = r_count - 1'b1;
                        end
                    end
                    swsid_pkg::FN_INSERT: begin
                        if (w_full) begin
                            n_stat = swsid_pkg::ST_FULL;
                        end else if (w_empty) begin
                            n_stat = swsid_pkg::ST_NOT_FOUND;
                        end else begin
                            w_op    = swsid_pkg::OP_START;
                            n_state = swsid_pkg::S_SCAN;
                        end
                    end
                    swsid_pkg::FN_DELETE: begin
                        if (w_empty) begin
                            n_stat = swsid_pkg::ST_NOT_FOUND;
                        end else begin
                            w_op    = swsid_pkg::OP_START;
                            n_state = swsid_pkg::S_SCAN;
                        end
                    end
                    swsid_pkg::FN_CLEAR: n_count = '0;
                    default: ;
                endcase
            end
            swsid_pkg::S_SCAN: begin
                if (|w_hit) begin
                    n_state = swsid_pkg::S_APPLY;
                end else if (CW'(r_k) == r_count - 1'b1) begin
                    n_stat  = swsid_pkg::ST_NOT_FOUND;
                    n_state = swsid_pkg::S_DONE;
                end else begin
                    w_op = swsid_pkg::OP_STEP;
                    n_k  = r_k + 1'b1;
                end
            end
            swsid_pkg::S_APPLY: begin
                if (r_func == swsid_pkg::FN_INSERT) begin
                    w_op    = swsid_pkg::OP_INS;
                    n_count = r_count + 1'b1;
                end else begin
                    w_op    = swsid_pkg::OP_DEL;
                    n_count = r_count - 1'b1;
                end
                n_state = swsid_pkg::S_DONE;
            end
            swsid_pkg::S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid  = 1'b1;
                    n_o_pop   = r_pop;
                    n_o_stat  = r_stat;
                    n_o_count = swsid_pkg::CountWidth'(r_count);
                    n_state   = swsid_pkg::S_IDLE;
                end
            end
            default: n_state = swsid_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_val     <= n_val;
        r_key     <= n_key;
        r_k       <= n_k;
        r_pop     <= n_pop;
        r_stat    <= n_stat;
        r_o_pop   <= n_o_pop;
        r_o_stat  <= n_o_stat;
        r_o_count <= n_o_count;
        if (!i_rst_n) begin
            r_state  <= swsid_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ===== rtl/core/swsid_cell.sv =====
module swsid_cell #(
    parameter int DEPTH = swsid_pkg::DefaultDepth,
    parameter int IDX   = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  swsid_pkg::t_cell_op               i_op,
    input  logic [swsid_pkg::DataWidth-1:0]   i_val,
    input  logic [swsid_pkg::DataWidth-1:0]   i_key,
    input  logic [$clog2(DEPTH+1)-1:0]        i_count,
    input  swsid_pkg::t_link                  i_prev,
    input  logic [swsid_pkg::DataWidth-1:0]   i_next_data,
    output swsid_pkg::t_link                  o_link,
    output logic                              o_hit
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [swsid_pkg::DataWidth-1:0] r_data, n_data;
    logic                            r_tok, n_tok;
    logic                            r_past, n_past;
    logic                            w_valid;

    assign w_valid     = CW'(IDX) < i_count;
    assign o_hit       = r_tok && w_valid && (r_data == i_key);
    assign o_link.data = r_data;
    assign o_link.tok  = r_tok;

    always_comb begin
        n_data = r_data;
        n_tok  = r_tok;
        n_past = r_past;
        unique case (i_op)
            swsid_pkg::OP_PUSH: n_data = i_prev.data;
            swsid_pkg::OP_POP:  n_data = i_next_data;
            swsid_pkg::OP_START: begin
                n_tok  = (IDX == 0);
                n_past = 1'b0;
            end
            swsid_pkg::OP_STEP: begin
                n_tok  = i_prev.tok;
                n_past = r_past | r_tok;
            end
            swsid_pkg::OP_INS: begin
                if (i_prev.tok) begin
                    n_data = i_val;
                end else if (!r_tok && !r_past) begin
                    n_data = i_prev.data;
                end
            end
            swsid_pkg::OP_DEL: begin
                if (!r_past) begin
                    n_data = i_next_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_past <= 1'b0;
        end else begin
            r_tok  <= n_tok;
            r_past <= n_past;
        end
    end

endmodule
